>>> rtl/core/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg: HTTP response deframer shared types and constants
// Beat structs, phase codes, keyword tables and character helpers.
// ----------------------------------------------------------------------------
package hrd_pkg;

   localparam int unsigned LengthBitsDefault   = 32;
   localparam int unsigned MaxHexDigitsDefault = 8;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_req;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        last;
      logic [9:0]  status_code;
      logic [31:0] content_length;
      logic        chunked;
      logic        gzip;
      logic [2:0]  error_code;
   } rsp_beat_type;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_BODY   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_STATUS   = 3'd1;
   localparam logic [2:0] ERR_LENGTH   = 3'd2;
   localparam logic [2:0] ERR_CHUNK    = 3'd3;
   localparam logic [2:0] ERR_REJECT   = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW = 3'd5;

   localparam logic [3:0] PH_VER    = 4'd0;
   localparam logic [3:0] PH_CODE   = 4'd1;
   localparam logic [3:0] PH_KEY    = 4'd2;
   localparam logic [3:0] PH_SKIP   = 4'd3;
   localparam logic [3:0] PH_CLSKIP = 4'd4;
   localparam logic [3:0] PH_CLDIG  = 4'd5;
   localparam logic [3:0] PH_ENDCR  = 4'd6;
   localparam logic [3:0] PH_BODY   = 4'd7;
   localparam logic [3:0] PH_CSIZE  = 4'd8;
   localparam logic [3:0] PH_CLF    = 4'd9;
   localparam logic [3:0] PH_CDATA  = 4'd10;
   localparam logic [3:0] PH_TRAIL1 = 4'd11;
   localparam logic [3:0] PH_TRAIL2 = 4'd12;
   localparam logic [3:0] PH_DONE   = 4'd13;

   localparam logic [9:0] ACCEPT_RESET = 10'd200;

   localparam logic [4:0] KW_LEN_SIZE = 5'd14;
   localparam logic [4:0] KW_TE_SIZE  = 5'd26;
   localparam logic [4:0] KW_CE_SIZE  = 5'd22;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;

   function automatic logic [7:0] magic_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = "H";
         3'd1:    c = "T";
         3'd2:    c = "T";
         3'd3:    c = "P";
         3'd4:    c = "/";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // byte at pos of keyword k; zero past the end (never matches: kill via size)
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [4:0] pos);
      logic [8*26-1:0] s;
      logic [4:0]      n;
      case (k)
         2'd0:    begin s = {"Content-Length", 96'h0}; n = KW_LEN_SIZE; end
         2'd1:    begin s = "Transfer-Encoding: chunked"; n = KW_TE_SIZE; end
         default: begin s = {"Content-Encoding: gzip", 32'h0}; n = KW_CE_SIZE; end
      endcase
      if (pos >= n) return 8'h00;
      return s[8*(25 - 32'(pos)) +: 8];
   endfunction

   function automatic logic [4:0] hex_val(input logic [7:0] b);
      // bit 4 set means not a hex digit
      if (b >= "0" && b <= "9") return {1'b0, 4'(b - 8'd48)};
      if (b >= "a" && b <= "f") return {1'b0, 4'(b - 8'd87)};
      if (b >= "A" && b <= "F") return {1'b0, 4'(b - 8'd55)};
      return 5'h10;
   endfunction

endpackage

>>> rtl/core/hrd_parser.sv
// ----------------------------------------------------------------------------
// hrd_parser: per-byte parse state and result generation
// Takes one registered byte per cycle while step is high, updates state, yields at most one beat.
// ----------------------------------------------------------------------------
module hrd_parser #(
   parameter int unsigned LENGTH_BITS    = hrd_pkg::LengthBitsDefault,
   parameter int unsigned MAX_HEX_DIGITS = hrd_pkg::MaxHexDigitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  hrd_pkg::req_beat_type beat,
   input  logic [9:0]           accepted_status,
   output logic                 out_valid,
   output hrd_pkg::rsp_beat_type out_beat
);

   localparam int unsigned HexCntBits = $clog2(MAX_HEX_DIGITS + 1);
   localparam logic [LENGTH_BITS-1:0] LenMax = '1;
   localparam logic [LENGTH_BITS-1:0] LenDiv10 = LenMax / 10;
   localparam logic [3:0]             LenMod10 = 4'(LenMax % 10);

   logic [3:0]             phase_ff, phase_in;
   logic [4:0]             pos_ff, pos_in;
   logic [2:0]             alive_ff, alive_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic [9:0]             status_ff, status_in;
   logic [LENGTH_BITS-1:0] hlen_ff, hlen_in;
   logic [1:0]             flags_ff, flags_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [LENGTH_BITS-1:0] cnt_ff, cnt_in;
   logic [HexCntBits-1:0]  hexn_ff, hexn_in;

   always_comb begin
      logic [3:0]             ph;
      logic [4:0]             pos;
      logic [2:0]             alv;
      logic [LENGTH_BITS-1:0] acc, hlen, rem, cnt;
      logic [9:0]             st;
      logic [1:0]             fl;
      logic [HexCntBits-1:0]  hn;
      logic [7:0]             b;
      logic                   dig;
      logic [3:0]             d;
      logic [4:0]             hv;
      logic [4:0]             npos;
      logic [13:0]            code;
      logic                   ov;
      logic                   do_hdr, do_cend;
      logic [1:0]             kind;
      logic [7:0]             dat;
      logic                   lst;
      logic [2:0]             err;
      logic                   emit;

      ph = phase_ff; pos = pos_ff; alv = alive_ff; acc = acc_ff; hlen = hlen_ff;
      rem = rem_ff; cnt = cnt_ff; st = status_ff; fl = flags_ff; hn = hexn_ff;
      if (beat.start_req) begin
         ph = hrd_pkg::PH_VER; pos = '0; alv = '1; acc = '0; hlen = '0;
         rem = '0; cnt = '0; st = '0; fl = '0; hn = '0;
      end
      b    = beat.in_byte;
      dig  = (b >= "0") && (b <= "9");
      d    = 4'(b - 8'd48);
      hv   = hrd_pkg::hex_val(b);
      emit = 1'b0; kind = hrd_pkg::KIND_DATA; dat = 8'h00; lst = 1'b0;
      err  = hrd_pkg::ERR_NONE;
      do_hdr = 1'b0; do_cend = 1'b0;
      npos = '0; code = '0; ov = 1'b0;

      unique case (ph)
         hrd_pkg::PH_VER: begin
            if (pos < 5'd5) begin
               if (b != hrd_pkg::magic_char(pos[2:0])) begin
                  emit = 1'b1; err = hrd_pkg::ERR_STATUS;
               end else begin
                  pos = pos + 5'd1;
               end
            end else if (b == hrd_pkg::CH_SPACE) begin
               ph = hrd_pkg::PH_CODE; pos = '0; acc = '0;
            end else if (b == hrd_pkg::CH_CR || b == hrd_pkg::CH_LF) begin
               emit = 1'b1; err = hrd_pkg::ERR_STATUS;
            end
         end
         hrd_pkg::PH_CODE: begin
            if (dig) begin
               // value saturates at 1000, so acc*10+d fits 14 bits
               code = {4'b0, acc[9:0]} * 14'd10 + {10'b0, d};
               if (code > 14'd1000) code = 14'd1000;
               acc = LENGTH_BITS'(code);
               pos = 5'd1;
            end else if (pos == 5'd0 || acc > LENGTH_BITS'(999)) begin
               emit = 1'b1; err = hrd_pkg::ERR_STATUS;
            end else begin
               st = acc[9:0];
               if (b == hrd_pkg::CH_LF) begin
                  ph = hrd_pkg::PH_KEY; pos = '0; alv = '1;
               end else begin
                  ph = hrd_pkg::PH_SKIP;
               end
            end
         end
         hrd_pkg::PH_KEY: begin
            if (b == hrd_pkg::CH_LF) begin
               if (pos == 5'd0) do_hdr = 1'b1;
               else begin ph = hrd_pkg::PH_KEY; pos = '0; alv = '1; end
            end else if (b == hrd_pkg::CH_CR) begin
               ph = (pos == 5'd0) ? hrd_pkg::PH_ENDCR : hrd_pkg::PH_SKIP;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  if (b != hrd_pkg::kw_char(2'(k), pos)) alv[k] = 1'b0;
               end
               npos = (pos < 5'd31) ? pos + 5'd1 : 5'd31;
               pos = npos;
               if (alv[0] && npos == hrd_pkg::KW_LEN_SIZE) begin
                  ph = hrd_pkg::PH_CLSKIP;
               end else if (alv[1] && npos == hrd_pkg::KW_TE_SIZE) begin
                  fl[0] = 1'b1; ph = hrd_pkg::PH_SKIP;
               end else if (alv[2] && npos == hrd_pkg::KW_CE_SIZE) begin
                  fl[1] = 1'b1; ph = hrd_pkg::PH_SKIP;
               end else if (alv == 3'b000) begin
                  ph = hrd_pkg::PH_SKIP;
               end
            end
         end
         hrd_pkg::PH_SKIP: begin
            if (b == hrd_pkg::CH_LF) begin
               ph = hrd_pkg::PH_KEY; pos = '0; alv = '1;
            end
         end
         hrd_pkg::PH_CLSKIP: begin
            if (dig) begin
               acc = LENGTH_BITS'(d); ph = hrd_pkg::PH_CLDIG;
            end else if (b == hrd_pkg::CH_CR || b == hrd_pkg::CH_LF) begin
               emit = 1'b1; err = hrd_pkg::ERR_LENGTH;
            end
         end
         hrd_pkg::PH_CLDIG: begin
            if (dig) begin
               // acc*10+d > max  <=>  acc > max/10, or equal and d > max%10
               ov = (acc > LenDiv10) || (acc == LenDiv10 && d > LenMod10);
               if (ov) begin
                  emit = 1'b1; err = hrd_pkg::ERR_OVERFLOW;
               end else begin
                  acc = (acc << 3) + (acc << 1) + LENGTH_BITS'(d);
               end
            end else begin
               hlen = acc;
               if (b == hrd_pkg::CH_LF) begin
                  ph = hrd_pkg::PH_KEY; pos = '0; alv = '1;
               end else begin
                  ph = hrd_pkg::PH_SKIP;
               end
            end
         end
         hrd_pkg::PH_ENDCR: do_hdr = 1'b1;
         hrd_pkg::PH_BODY: begin
            cnt = cnt + 1'b1;
            emit = 1'b1; dat = b;
            if (cnt >= hlen) begin lst = 1'b1; ph = hrd_pkg::PH_DONE; end
         end
         hrd_pkg::PH_CSIZE: begin
            if (!hv[4]) begin
               if (hn >= HexCntBits'(MAX_HEX_DIGITS) || acc[LENGTH_BITS-1 -: 4] != 4'h0)
               begin
                  emit = 1'b1; err = hrd_pkg::ERR_OVERFLOW;
               end else begin
                  acc = {acc[LENGTH_BITS-5:0], hv[3:0]};
                  hn = hn + 1'b1;
               end
            end else if (b == hrd_pkg::CH_CR) begin
               ph = hrd_pkg::PH_CLF;
            end else if (b == hrd_pkg::CH_LF) begin
               do_cend = 1'b1;
            end else begin
               emit = 1'b1; err = hrd_pkg::ERR_CHUNK;
            end
         end
         hrd_pkg::PH_CLF: begin
            if (b == hrd_pkg::CH_LF) do_cend = 1'b1;
            else begin emit = 1'b1; err = hrd_pkg::ERR_CHUNK; end
         end
         hrd_pkg::PH_CDATA: begin
            cnt = cnt + 1'b1;
            rem = rem - 1'b1;
            if (rem == '0) ph = hrd_pkg::PH_TRAIL1;
            emit = 1'b1; dat = b;
         end
         hrd_pkg::PH_TRAIL1: ph = hrd_pkg::PH_TRAIL2;
         hrd_pkg::PH_TRAIL2: begin
            ph = hrd_pkg::PH_CSIZE; acc = '0; hn = '0;
         end
         default: ;
      endcase

      if (do_hdr) begin
         emit = 1'b1; kind = hrd_pkg::KIND_HEADER;
         if (st != accepted_status) begin
            err = hrd_pkg::ERR_REJECT;
         end else begin
            acc = '0; hn = '0; cnt = '0;
            if (fl[0]) ph = hrd_pkg::PH_CSIZE;
            else if (hlen == '0) begin ph = hrd_pkg::PH_DONE; lst = 1'b1; end
            else ph = hrd_pkg::PH_BODY;
         end
      end
      if (do_cend) begin
         if (hn == '0) begin
            emit = 1'b1; err = hrd_pkg::ERR_CHUNK;
         end else if (acc == '0) begin
            emit = 1'b1; kind = hrd_pkg::KIND_BODY; lst = 1'b1; ph = hrd_pkg::PH_DONE;
         end else begin
            rem = acc; ph = hrd_pkg::PH_CDATA;
         end
      end
      if (err != hrd_pkg::ERR_NONE) begin
         kind = hrd_pkg::KIND_ERROR; lst = 1'b1; ph = hrd_pkg::PH_DONE;
      end

      phase_in = ph; pos_in = pos; alive_in = alv; acc_in = acc; hlen_in = hlen;
      rem_in = rem; cnt_in = cnt; status_in = st; flags_in = fl; hexn_in = hn;
      out_valid = step && emit;
      out_beat.kind           = kind;
      out_beat.data_byte      = dat;
      out_beat.last           = lst;
      out_beat.status_code    = st;
      out_beat.content_length = 32'(hlen);
      out_beat.chunked        = fl[0];
      out_beat.gzip           = fl[1];
      out_beat.error_code     = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hrd_pkg::PH_VER;
         pos_ff    <= '0;
         alive_ff  <= '1;
         acc_ff    <= '0;
         status_ff <= '0;
         hlen_ff   <= '0;
         flags_ff  <= '0;
         rem_ff    <= '0;
         cnt_ff    <= '0;
         hexn_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         alive_ff  <= alive_in;
         acc_ff    <= acc_in;
         status_ff <= status_in;
         hlen_ff   <= hlen_in;
         flags_ff  <= flags_in;
         rem_ff    <= rem_in;
         cnt_ff    <= cnt_in;
         hexn_ff   <= hexn_in;
      end
   end

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hrd_pkg::PH_DONE && step && !beat.start_req) |-> !out_valid)
      else $error("result from finished response");
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_beat.kind == hrd_pkg::KIND_ERROR) |=> phase_ff == hrd_pkg::PH_DONE)
      else $error("error did not end response");
   a_hex_bound: assert property (@(posedge clock) disable iff (reset)
      hexn_ff <= HexCntBits'(MAX_HEX_DIGITS))
      else $error("hex digit count overrun");

endmodule

>>> rtl/core/http_response_deframer_top.sv
// Path: an accepted byte is held in the input register; parse logic writes its
// result beat into the result register. Throughput: one byte per cycle, set by
// the single-pass parse step, unless the receiver stalls the result register.
// Reset: synchronous, active high; clears parse state and sets the accepted
// status to 200.
// ----------------------------------------------------------------------------
// http_response_deframer_top: HTTP/1.1 response deframer
// Parses status and header lines, then emits counted or chunked body bytes.
// ----------------------------------------------------------------------------
module http_response_deframer_top #(
   parameter int unsigned LENGTH_BITS    = hrd_pkg::LengthBitsDefault,
   parameter int unsigned MAX_HEX_DIGITS = hrd_pkg::MaxHexDigitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hrd_pkg::req_beat_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hrd_pkg::rsp_beat_type rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [9:0]            csr_write_data
);

   logic                  in_valid_ff;
   hrd_pkg::req_beat_type in_beat_ff;
   logic                  out_valid_ff;
   hrd_pkg::rsp_beat_type out_beat_ff;
   logic [9:0]            accept_ff;
   logic                  step;
   logic                  p_valid;
   hrd_pkg::rsp_beat_type p_beat;
   logic                  out_free;

   // Stage advances when the result register can take whatever it yields.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_ff <= hrd_pkg::ACCEPT_RESET;
      end else if (csr_write_enable) begin
         accept_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_beat_ff <= req_payload;
      end
   end

   hrd_parser #(
      .LENGTH_BITS(LENGTH_BITS),
      .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .step(step),
      .beat(in_beat_ff),
      .accepted_status(accept_ff),
      .out_valid(p_valid),
      .out_beat(p_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= p_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && p_valid) begin
         out_beat_ff <= p_beat;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_beat_ff;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> out_valid_ff)
      else $error("stalled result dropped");
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall without held beat");
   a_step_room: assert property (@(posedge clock) disable iff (reset)
      step |-> (!out_valid_ff || !rsp_stall))
      else $error("step into full result register");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: HTTP response deframer check
// Drives whole responses (status line, headers, counted or chunked bodies, plus
// damaged and cut-off streams) byte by byte, predicts every result beat in a
// scoreboard and compares the beats that leave the block, field by field.
// ----------------------------------------------------------------------------
import hrd_pkg::*;

class deframer_scoreboard;
   localparam longint unsigned LenMask = 64'hFFFF_FFFF;

   logic [9:0]      accept_code;
   logic [3:0]      ph;
   int unsigned     mpos;
   logic [3:0]      alive;
   longint unsigned acc;
   logic [9:0]      hstat;
   longint unsigned hlen;
   logic [1:0]      flags;
   longint unsigned remain;
   longint unsigned nbody;
   int unsigned     nhex;
   string           kw_text[3];
   int unsigned     kw_len[3];
   string           magic;
   rsp_beat_type    due_beats[$];
   int              mismatches;

   function new();
      kw_text = '{"Content-Length", "Transfer-Encoding: chunked", "Content-Encoding: gzip"};
      kw_len = '{14, 26, 22};
      magic = "HTTP/";
      accept_code = ACCEPT_RESET;
      mismatches = 0;
      clear_parse();
   endfunction

   function void clear_parse();
      ph = PH_VER;
      mpos = 0;
      alive = 4'hf;
      acc = 0;
      hstat = 0;
      hlen = 0;
      flags = 0;
      remain = 0;
      nbody = 0;
      nhex = 0;
   endfunction

   function void emit(logic [1:0] kind, logic [7:0] data, logic last, logic [2:0] err);
      rsp_beat_type r;
      r.kind = kind;
      r.data_byte = data;
      r.last = last;
      r.status_code = hstat;
      r.content_length = hlen[31:0];
      r.chunked = flags[0];
      r.gzip = flags[1];
      r.error_code = err;
      due_beats.insert(due_beats.size(), r);
   endfunction

   function void abort(logic [2:0] err);
      ph = PH_DONE;
      emit(KIND_ERROR, 8'h00, 1'b1, err);
   endfunction

   function void new_line();
      ph = PH_KEY;
      mpos = 0;
      alive = 4'hf;
   endfunction

   function void header_end();
      if (hstat != accept_code) begin
         abort(ERR_REJECT);
         return;
      end
      acc = 0;
      nhex = 0;
      nbody = 0;
      if (flags[0]) begin
         ph = PH_CSIZE;
         emit(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
      end else if (hlen == 0) begin
         ph = PH_DONE;
         emit(KIND_HEADER, 8'h00, 1'b1, ERR_NONE);
      end else begin
         ph = PH_BODY;
         emit(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
      end
   endfunction

   function void header_byte(logic [7:0] b);
      if (b == CH_LF) begin
         if (mpos == 0) header_end();
         else new_line();
         return;
      end
      if (b == CH_CR) begin
         ph = (mpos == 0) ? PH_ENDCR : PH_SKIP;
         return;
      end
      for (int k = 0; k < 3; k++)
         if (alive[k] && (mpos >= kw_len[k] || b != kw_text[k][mpos])) alive[k] = 1'b0;
      mpos = (mpos < 31) ? mpos + 1 : 31;
      if (alive[0] && mpos == kw_len[0]) ph = PH_CLSKIP;
      else if (alive[1] && mpos == kw_len[1]) begin
         flags[0] = 1'b1;
         ph = PH_SKIP;
      end else if (alive[2] && mpos == kw_len[2]) begin
         flags[1] = 1'b1;
         ph = PH_SKIP;
      end else if (alive[2:0] == 3'b000) ph = PH_SKIP;
   endfunction

   function void size_line_end();
      if (nhex == 0) abort(ERR_CHUNK);
      else if (acc == 0) begin
         ph = PH_DONE;
         emit(KIND_BODY, 8'h00, 1'b1, ERR_NONE);
      end else begin
         remain = acc;
         ph = PH_CDATA;
      end
   endfunction

   // note one accepted input byte and queue the beat it should cause
   function void take_byte(logic [7:0] b, logic start);
      bit          dig;
      int unsigned d;
      int          hv;
      dig = (b >= "0" && b <= "9");
      d = b - 8'd48;
      hv = -1;
      if (b >= "0" && b <= "9") hv = b - 8'd48;
      else if (b >= "a" && b <= "f") hv = b - 8'd87;
      else if (b >= "A" && b <= "F") hv = b - 8'd55;
      if (start) clear_parse();
      case (ph)
         PH_VER: begin
            if (mpos < 5) begin
               if (b != magic[mpos]) abort(ERR_STATUS);
               else mpos++;
            end else if (b == CH_SPACE) begin
               ph = PH_CODE;
               mpos = 0;
               acc = 0;
            end else if (b == CH_CR || b == CH_LF) abort(ERR_STATUS);
         end
         PH_CODE: begin
            if (dig) begin
               acc = acc * 10 + d;
               if (acc > 1000) acc = 1000;
               mpos = 1;
            end else if (mpos == 0 || acc > 999) abort(ERR_STATUS);
            else begin
               hstat = acc[9:0];
               if (b == CH_LF) new_line();
               else ph = PH_SKIP;
            end
         end
         PH_KEY: header_byte(b);
         PH_SKIP: if (b == CH_LF) new_line();
         PH_CLSKIP: begin
            if (dig) begin
               acc = d;
               ph = PH_CLDIG;
            end else if (b == CH_CR || b == CH_LF) abort(ERR_LENGTH);
         end
         PH_CLDIG: begin
            if (dig) begin
               if (acc > (LenMask - d) / 10) abort(ERR_OVERFLOW);
               else acc = acc * 10 + d;
            end else begin
               hlen = acc;
               if (b == CH_LF) new_line();
               else ph = PH_SKIP;
            end
         end
         PH_ENDCR: header_end();
         PH_BODY: begin
            nbody++;
            if (nbody >= hlen) begin
               ph = PH_DONE;
               emit(KIND_DATA, b, 1'b1, ERR_NONE);
            end else emit(KIND_DATA, b, 1'b0, ERR_NONE);
         end
         PH_CSIZE: begin
            if (hv >= 0) begin
               if (nhex >= 8 || acc > (LenMask >> 4)) abort(ERR_OVERFLOW);
               else begin
                  acc = (acc << 4) | hv;
                  nhex++;
               end
            end else if (b == CH_CR) ph = PH_CLF;
            else if (b == CH_LF) size_line_end();
            else abort(ERR_CHUNK);
         end
         PH_CLF: begin
            if (b == CH_LF) size_line_end();
            else abort(ERR_CHUNK);
         end
         PH_CDATA: begin
            nbody++;
            remain--;
            if (remain == 0) ph = PH_TRAIL1;
            emit(KIND_DATA, b, 1'b0, ERR_NONE);
         end
         PH_TRAIL1: ph = PH_TRAIL2;
         PH_TRAIL2: begin
            ph = PH_CSIZE;
            acc = 0;
            nhex = 0;
         end
         default: ;
      endcase
   endfunction

   function void check_beat(rsp_beat_type got);
      rsp_beat_type exp;
      if (due_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %p", got);
         return;
      end
      exp = due_beats.pop_front();
      if (got.kind !== exp.kind || got.data_byte !== exp.data_byte ||
          got.last !== exp.last || got.status_code !== exp.status_code ||
          got.content_length !== exp.content_length || got.chunked !== exp.chunked ||
          got.gzip !== exp.gzip || got.error_code !== exp.error_code) begin
         mismatches++;
         if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
   endfunction
endclass

module testbench;
   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_beat_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_beat_type rsp_payload;
   logic         csr_write_enable;
   logic [9:0]   csr_write_data;

   deframer_scoreboard sb;
   logic [7:0] stream[$];
   int         burst_left;
   int         stall_mode;
   int         mode_left;
   int         bytes_sent;

   http_response_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   // receiver stall pattern: stretches of no stall, light and heavy stalling
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(2);
         mode_left <= $urandom_range(80, 10);
      end else mode_left <= mode_left - 1;
      case (stall_mode)
         1: rsp_stall <= ($urandom_range(3) == 0);
         2: rsp_stall <= ($urandom_range(2) != 0);
         default: rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_beat(rsp_payload);

   task automatic push_byte(input logic [7:0] b, input logic s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(30, 1);
         gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= '{in_byte: b, start_req: s};
      do @(posedge clock); while (req_stall);
      sb.take_byte(b, s);
      bytes_sent++;
   endtask

   task automatic send_stream();
      foreach (stream[i]) push_byte(stream[i], i == 0);
      stream.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) stream.insert(stream.size(), s[i]);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.due_beats.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_accept(input logic [9:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.accept_code = v;
   endtask

   task automatic add_random_bytes(input int n);
      repeat (n) stream.insert(stream.size(), 8'($urandom_range(255)));
   endtask

   task automatic make_response();
      int    code;
      int    kind;
      int    n;
      string eol;
      code = ($urandom_range(6) == 0) ? $urandom_range(999) : sb.accept_code;
      eol = ($urandom_range(4) == 0) ? "\n" : "\r\n";
      if ($urandom_range(30) == 0) add_text("HTTP/1.0  ");
      else add_text("HTTP/1.1 ");
      if ($urandom_range(1)) add_text($sformatf("%03d", code));
      else add_text($sformatf("%0d", code));
      add_text({" OK", eol});
      kind = $urandom_range(2);
      if ($urandom_range(2) == 0) add_text({"Server: unit", eol});
      if ($urandom_range(8) == 0) add_text({"Content-Len: 4", eol});
      n = $urandom_range(24);
      if (kind == 0) add_text({$sformatf("Content-Length: %0d", n), eol});
      if (kind == 1) add_text({"Transfer-Encoding: chunked", eol});
      if ($urandom_range(2) == 0) add_text({"Content-Encoding: gzip", eol});
      if ($urandom_range(3) == 0) add_text("\r");
      else add_text(eol);
      if (kind == 0) add_random_bytes(n + $urandom_range(3));
      else if (kind == 1) begin
         repeat ($urandom_range(3)) begin
            string hx;
            n = $urandom_range(12, 1);
            hx = $sformatf("%0h", n);
            if ($urandom_range(1)) hx = hx.toupper();
            if ($urandom_range(4) == 0) hx = {"0", hx};
            add_text({hx, eol});
            add_random_bytes(n);
            add_text("\r\n");
         end
         add_text({"0", eol});
      end else add_random_bytes($urandom_range(3));
      if ($urandom_range(9) == 0) stream[$urandom_range(stream.size() - 1)] = $urandom_range(255);
      if ($urandom_range(19) == 0) begin
         n = $urandom_range(stream.size() - 1, 1);
         while (stream.size() > n) void'(stream.pop_back());
      end
   endtask

   task automatic directed();
      string msgs[$];
      msgs = '{
         "HTTX/1.1 200\r\n",
         "HTTP/1.1\r\n",
         "HTTP/1.1 x\r\n",
         "HTTP/1.1 1000 \r\n",
         "HTTP/1.1 404 NF\r\n\r\n",
         "HTTP/1.1 200\nContent-Length\r\n",
         "HTTP/1.1 200\nContent-Length: 99999999999\r\n",
         "HTTP/1.1 200\nContent-Length: 4294967295\r\nX-A: b\r\rZabc",
         "HTTP/1.1 200\r\n\r\nextra",
         "HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n0\r\n",
         "HTTP/1.1 200\nTransfer-Encoding: chunked\n\n1FFFFFFFF\r\n",
         "HTTP/1.1 200\nTransfer-Encoding: chunked\n\nFFFFFFFF\r\nab",
         "HTTP/1.1 200\nTransfer-Encoding: chunked\n\n5x",
         "HTTP/1.1 200\nTransfer-Encoding: chunked\n\n5\rX",
         "HTTP/1.1 200\nTransfer-Encoding: chunked\n\n\n",
         "HTTP/1.1 200\nContent-Encoding: gzip\nTransfer-Encoding: chunked\n\n3\nabcXY0\n",
         "HTTP/1.1 200\nContent-Length: 7\nContent-Length: 2\n\nxyz",
         "HTTP/1.1 2050\r\n"
      };
      foreach (msgs[i]) begin
         add_text(msgs[i]);
         send_stream();
      end
      add_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
      stream.insert(stream.size(), 8'hff);
      stream.insert(stream.size(), 8'h00);
      stream.insert(stream.size(), 8'h7f);
      send_stream();
   endtask

   initial begin
      logic [9:0] accepts[6];
      int         base;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      burst_left = 0;
      stall_mode = 0;
      mode_left = 0;
      bytes_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed();
      base = bytes_sent;
      accepts = '{10'd200, 10'd0, 10'd999, 10'd200, 10'($urandom_range(999)), 10'd404};
      foreach (accepts[p]) begin
         wait_idle();
         write_accept(accepts[p]);
         while (bytes_sent < base + 170 * (p + 1)) begin
            make_response();
            send_stream();
         end
      end
      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_beats.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule

>>> sim.f
rtl/core/hrd_pkg.sv
rtl/core/hrd_parser.sv
rtl/core/http_response_deframer_top.sv
verif/testbench.sv
